// File: rtl/core/jhcd_pkg.sv
// shared constants, types and tables of the jpeg huffman coefficient decoder
`default_nettype none
package jhcd_pkg;

   localparam int ENTRIES_PER_TABLE = 256;
   localparam int COMPONENTS        = 4;
   localparam int MAX_CODE_LEN      = 16;
   localparam int TABLES            = 4;
   localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
   localparam int CNT_W             = $clog2(ENTRIES_PER_TABLE + 1);
   localparam int TAB_W             = $clog2(TABLES);

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_BIT   = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_NO_CODE  = 2'd1;
   localparam logic [1:0] STAT_BAD_SYM  = 2'd2;
   localparam logic [1:0] STAT_OVERRUN  = 2'd3;

   typedef struct packed {
      logic       done;
      logic       found;
      logic [7:0] symbol;
   } search_result_type;

   function automatic logic [5:0] zz_to_nat(input logic [5:0] zz);
      logic [5:0] nat;
      case (zz)
         6'd0: nat = 6'd0;   6'd1: nat = 6'd1;   6'd2: nat = 6'd8;   6'd3: nat = 6'd16;
         6'd4: nat = 6'd9;   6'd5: nat = 6'd2;   6'd6: nat = 6'd3;   6'd7: nat = 6'd10;
         6'd8: nat = 6'd17;  6'd9: nat = 6'd24;  6'd10: nat = 6'd32; 6'd11: nat = 6'd25;
         6'd12: nat = 6'd18; 6'd13: nat = 6'd11; 6'd14: nat = 6'd4;  6'd15: nat = 6'd5;
         6'd16: nat = 6'd12; 6'd17: nat = 6'd19; 6'd18: nat = 6'd26; 6'd19: nat = 6'd33;
         6'd20: nat = 6'd40; 6'd21: nat = 6'd48; 6'd22: nat = 6'd41; 6'd23: nat = 6'd34;
         6'd24: nat = 6'd27; 6'd25: nat = 6'd20; 6'd26: nat = 6'd13; 6'd27: nat = 6'd6;
         6'd28: nat = 6'd7;  6'd29: nat = 6'd14; 6'd30: nat = 6'd21; 6'd31: nat = 6'd28;
         6'd32: nat = 6'd35; 6'd33: nat = 6'd42; 6'd34: nat = 6'd49; 6'd35: nat = 6'd56;
         6'd36: nat = 6'd57; 6'd37: nat = 6'd50; 6'd38: nat = 6'd43; 6'd39: nat = 6'd36;
         6'd40: nat = 6'd29; 6'd41: nat = 6'd22; 6'd42: nat = 6'd15; 6'd43: nat = 6'd23;
         6'd44: nat = 6'd30; 6'd45: nat = 6'd37; 6'd46: nat = 6'd44; 6'd47: nat = 6'd51;
         6'd48: nat = 6'd58; 6'd49: nat = 6'd59; 6'd50: nat = 6'd52; 6'd51: nat = 6'd45;
         6'd52: nat = 6'd38; 6'd53: nat = 6'd31; 6'd54: nat = 6'd39; 6'd55: nat = 6'd46;
         6'd56: nat = 6'd53; 6'd57: nat = 6'd60; 6'd58: nat = 6'd61; 6'd59: nat = 6'd54;
         6'd60: nat = 6'd47; 6'd61: nat = 6'd55; 6'd62: nat = 6'd62; 6'd63: nat = 6'd63;
         default: nat = 6'd0;
      endcase
      return nat;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/jhcd_code_table.sv
// huffman code store with entry counts and a linear search over one table
`default_nettype none
module jhcd_code_table (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         wr_en,
   input  wire logic [jhcd_pkg::TAB_W-1:0]   wr_tab,
   input  wire logic [4:0]                   wr_len,
   input  wire logic [15:0]                  wr_code,
   input  wire logic [7:0]                   wr_sym,
   input  wire logic                         search_start,
   input  wire logic [jhcd_pkg::TAB_W-1:0]   search_tab,
   input  wire logic [4:0]                   search_len,
   input  wire logic [15:0]                  search_code,
   output jhcd_pkg::search_result_type       result
);

   localparam int ADDR_W = jhcd_pkg::TAB_W + jhcd_pkg::IDX_W;

   logic [28:0] mem [jhcd_pkg::TABLES * jhcd_pkg::ENTRIES_PER_TABLE];
   logic [28:0] rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;

   logic [jhcd_pkg::CNT_W-1:0] count_ff [jhcd_pkg::TABLES];
   logic [jhcd_pkg::CNT_W-1:0] idx_ff, idx_in;
   logic busy_ff, busy_in, rd_vld_ff, rd_vld_in;
   logic [jhcd_pkg::TAB_W-1:0] tab_ff;
   logic [4:0] len_ff;
   logic [15:0] code_ff;
   logic [jhcd_pkg::CNT_W-1:0] n;
   logic match, issue;
   logic wr_ok;

   assign n     = count_ff[tab_ff];
   assign wr_ok = wr_en && (count_ff[wr_tab] < jhcd_pkg::CNT_W'(jhcd_pkg::ENTRIES_PER_TABLE));
   assign match = busy_ff && rd_vld_ff && (rd_data_ff[4:0] == len_ff)
                  && (rd_data_ff[20:5] == code_ff);
   assign issue = busy_ff && !match && (idx_ff < n);
   assign rd_addr = {tab_ff, idx_ff[jhcd_pkg::IDX_W-1:0]};

   always_comb begin
      busy_in   = busy_ff;
      idx_in    = idx_ff;
      rd_vld_in = 1'b0;
      result    = '0;
      if (busy_ff) begin
         if (match) begin
            result.done   = 1'b1;
            result.found  = 1'b1;
            result.symbol = rd_data_ff[28:21];
            busy_in       = 1'b0;
         end else if (!rd_vld_ff && !(idx_ff < n)) begin
            result.done = 1'b1;
            busy_in     = 1'b0;
         end else if (issue) begin
            idx_in    = idx_ff + 1'b1;
            rd_vld_in = 1'b1;
         end
      end
      if (search_start) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_ok) begin
         mem[{wr_tab, count_ff[wr_tab][jhcd_pkg::IDX_W-1:0]}] <= {wr_sym, wr_code, wr_len};
      end
      if (search_start) begin
         tab_ff  <= search_tab;
         len_ff  <= search_len;
         code_ff <= search_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < jhcd_pkg::TABLES; i++) begin
            count_ff[i] <= '0;
         end
         busy_ff   <= 1'b0;
         idx_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_ok) begin
            count_ff[wr_tab] <= count_ff[wr_tab] + 1'b1;
         end
         busy_ff   <= busy_in;
         idx_ff    <= idx_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/jpeg_huffman_coefficient_decoder_top.sv
// top level of the jpeg huffman coefficient decoder
`default_nettype none
// Decodes one baseline 8x8 block from a stream of single bits, giving coefficients in zigzag
// order, each with its natural-order position, the 64th marked by rsp_tlast; error results
// also carry tlast and a nonzero tuser. A stream bit during code matching scans the selected
// table in the code memory one entry per cycle, up to the first entry that matches or the end
// of the entries loaded into that table (at most 256). A decoded symbol holds the input while
// its coefficients drain through the output register, and longer while the output stalls.
// The code memory needs no clearing after reset.
module jpeg_huffman_coefficient_decoder_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // table_sel[1:0], code_length[6:2], code_bits[22:7], code_symbol[30:23], dc_table[31],
   // ac_table[32], component[34:33], stream_bit[35], zero[39:36]
   input  wire logic [39:0] req_tdata,
   // op[1:0]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // position[5:0], coefficient[21:6], zero[23:22]
   output logic [23:0]      rsp_tdata,
   // status[1:0]
   output logic [1:0]       rsp_tuser,
   output logic             rsp_tlast
);

   typedef enum logic [1:0] {ST_READY, ST_SCAN, ST_EMIT, ST_FAIL} state_type;
   typedef enum logic [1:0] {PH_IDLE, PH_CODE, PH_MAG} phase_type;

   logic [1:0]  f_table_sel;
   logic [4:0]  f_code_length;
   logic [15:0] f_code_bits;
   logic [7:0]  f_code_symbol;
   logic        f_dc_table, f_ac_table, f_stream_bit;
   logic [1:0]  f_component;

   assign f_table_sel   = req_tdata[1:0];
   assign f_code_length = req_tdata[6:2];
   assign f_code_bits   = req_tdata[22:7];
   assign f_code_symbol = req_tdata[30:23];
   assign f_dc_table    = req_tdata[31];
   assign f_ac_table    = req_tdata[32];
   assign f_component   = req_tdata[34:33];
   assign f_stream_bit  = req_tdata[35];

   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic [15:0] pred_ff [4];
   logic [15:0] pred_in [4];
   logic [6:0]  coef_ff, coef_in;
   logic [15:0] acc_ff, acc_in;
   logic [4:0]  bits_ff, bits_in;
   logic [7:0]  prs_ff, prs_in;
   logic [3:0]  sel_ff, sel_in;
   logic [5:0]  run_ff, run_in;
   logic [15:0] val_ff, val_in;
   logic [1:0]  fstat_ff, fstat_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [5:0]  rsp_pos_ff, rsp_pos_in;
   logic [15:0] rsp_coef_ff, rsp_coef_in;
   logic        rsp_last_ff, rsp_last_in;
   logic [1:0]  rsp_stat_ff, rsp_stat_in;

   logic        accept, slot_free;
   logic [15:0] acc_new;
   logic [4:0]  bits_new;
   logic [1:0]  comp;
   logic        search_start;
   logic [1:0]  search_tab;
   logic [4:0]  mag_size;
   logic [16:0] mag_mask;
   logic [15:0] mag_val;
   logic [3:0]  sym_run, sym_size;
   logic [7:0]  run_end;
   logic [1:0]  comp_clamped;
   jhcd_pkg::search_result_type sres;

   assign req_tready = (state_ff == ST_READY);
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign acc_new    = {acc_ff[14:0], f_stream_bit};
   assign bits_new   = bits_ff + 1'b1;
   assign comp       = sel_ff[3:2];
   assign search_tab = (coef_ff == 7'd0) ? {1'b0, sel_ff[0]} : {1'b1, sel_ff[1]};
   assign search_start = accept && (req_tuser == jhcd_pkg::OP_BIT) && (phase_ff == PH_CODE);
   assign comp_clamped = (f_component > 2'(jhcd_pkg::COMPONENTS - 1))
                         ? 2'(jhcd_pkg::COMPONENTS - 1) : f_component;

   assign mag_size = (coef_ff == 7'd0) ? prs_ff[4:0] : {1'b0, prs_ff[3:0]};
   assign mag_mask = (17'd1 << mag_size) - 17'd1;
   assign mag_val  = acc_new[4'(mag_size - 5'd1)] ? acc_new : (acc_new - mag_mask[15:0]);
   assign sym_run  = sres.symbol[7:4];
   assign sym_size = sres.symbol[3:0];
   assign run_end  = {1'b0, coef_ff} + {4'd0, sym_run} + 8'd1;

   jhcd_code_table u_table (
      .clock        (clock),
      .reset        (reset),
      .wr_en        (accept && (req_tuser == jhcd_pkg::OP_LOAD)),
      .wr_tab       (f_table_sel),
      .wr_len       (f_code_length),
      .wr_code      (f_code_bits),
      .wr_sym       (f_code_symbol),
      .search_start (search_start),
      .search_tab   (search_tab),
      .search_len   (bits_new),
      .search_code  (acc_new),
      .result       (sres)
   );

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      pred_in  = pred_ff;
      coef_in  = coef_ff;
      acc_in   = acc_ff;
      bits_in  = bits_ff;
      prs_in   = prs_ff;
      sel_in   = sel_ff;
      run_in   = run_ff;
      val_in   = val_ff;
      fstat_in = fstat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_pos_in   = rsp_pos_ff;
      rsp_coef_in  = rsp_coef_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_stat_in  = rsp_stat_ff;
      case (state_ff)
         ST_READY: begin
            if (accept) begin
               case (req_tuser)
                  jhcd_pkg::OP_START: begin
                     sel_in   = {comp_clamped, f_ac_table, f_dc_table};
                     coef_in  = '0;
                     acc_in   = '0;
                     bits_in  = '0;
                     prs_in   = '0;
                     phase_in = PH_CODE;
                  end
                  jhcd_pkg::OP_CLEAR: begin
                     for (int i = 0; i < 4; i++) begin
                        pred_in[i] = '0;
                     end
                  end
                  jhcd_pkg::OP_BIT: begin
                     if (phase_ff == PH_CODE) begin
                        acc_in   = acc_new;
                        bits_in  = bits_new;
                        state_in = ST_SCAN;
                     end else if (phase_ff == PH_MAG) begin
                        acc_in  = acc_new;
                        bits_in = bits_new;
                        if (mag_size == 5'd0 || mag_size > 5'd16) begin
                           fstat_in = jhcd_pkg::STAT_BAD_SYM;
                           state_in = ST_FAIL;
                        end else if (!(bits_new < mag_size)) begin
                           acc_in  = '0;
                           bits_in = '0;
                           if (coef_ff == 7'd0) begin
                              pred_in[comp] = pred_ff[comp] + mag_val;
                              val_in = pred_ff[comp] + mag_val;
                              run_in = '0;
                           end else begin
                              val_in = mag_val;
                              run_in = {2'b00, prs_ff[7:4]};
                           end
                           state_in = ST_EMIT;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (sres.done) begin
               if (!sres.found) begin
                  if (bits_ff >= 5'(jhcd_pkg::MAX_CODE_LEN)) begin
                     fstat_in = jhcd_pkg::STAT_NO_CODE;
                     state_in = ST_FAIL;
                  end else begin
                     state_in = ST_READY;
                  end
               end else begin
                  acc_in  = '0;
                  bits_in = '0;
                  prs_in  = sres.symbol;
                  if (coef_ff == 7'd0) begin
                     if (sres.symbol > 8'd16) begin
                        fstat_in = jhcd_pkg::STAT_BAD_SYM;
                        state_in = ST_FAIL;
                     end else if (sres.symbol == 8'd0) begin
                        run_in   = '0;
                        val_in   = pred_ff[comp];
                        state_in = ST_EMIT;
                     end else begin
                        phase_in = PH_MAG;
                        state_in = ST_READY;
                     end
                  end else if (sym_size == 4'd0 && sym_run == 4'd0) begin
                     run_in   = 6'(7'd63 - coef_ff);
                     val_in   = '0;
                     state_in = ST_EMIT;
                  end else if (sym_size == 4'd0 && sym_run != 4'hF) begin
                     fstat_in = jhcd_pkg::STAT_BAD_SYM;
                     state_in = ST_FAIL;
                  end else if (run_end > 8'd64) begin
                     fstat_in = jhcd_pkg::STAT_OVERRUN;
                     state_in = ST_FAIL;
                  end else if (sym_size == 4'd0) begin
                     run_in   = {2'b00, sym_run};
                     val_in   = '0;
                     state_in = ST_EMIT;
                  end else begin
                     phase_in = PH_MAG;
                     state_in = ST_READY;
                  end
               end
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = jhcd_pkg::zz_to_nat(coef_ff[5:0]);
               rsp_coef_in  = (run_ff == 6'd0) ? val_ff : 16'd0;
               rsp_last_in  = (coef_ff == 7'd63);
               rsp_stat_in  = jhcd_pkg::STAT_OK;
               coef_in      = coef_ff + 1'b1;
               if (run_ff == 6'd0 || coef_ff == 7'd63) begin
                  phase_in = (coef_ff == 7'd63) ? PH_IDLE : PH_CODE;
                  state_in = ST_READY;
               end else begin
                  run_in = run_ff - 1'b1;
               end
            end
         end
         ST_FAIL: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = jhcd_pkg::zz_to_nat(coef_ff[5:0]);
               rsp_coef_in  = '0;
               rsp_last_in  = 1'b1;
               rsp_stat_in  = fstat_ff;
               phase_in     = PH_IDLE;
               state_in     = ST_READY;
            end
         end
         default: state_in = ST_READY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_READY;
         phase_ff <= PH_IDLE;
         for (int i = 0; i < 4; i++) begin
            pred_ff[i] <= '0;
         end
         coef_ff      <= '0;
         acc_ff       <= '0;
         bits_ff      <= '0;
         prs_ff       <= '0;
         sel_ff       <= '0;
         run_ff       <= '0;
         val_ff       <= '0;
         fstat_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_pos_ff   <= '0;
         rsp_coef_ff  <= '0;
         rsp_last_ff  <= 1'b0;
         rsp_stat_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         pred_ff      <= pred_in;
         coef_ff      <= coef_in;
         acc_ff       <= acc_in;
         bits_ff      <= bits_in;
         prs_ff       <= prs_in;
         sel_ff       <= sel_in;
         run_ff       <= run_in;
         val_ff       <= val_in;
         fstat_ff     <= fstat_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_pos_ff   <= rsp_pos_in;
         rsp_coef_ff  <= rsp_coef_in;
         rsp_last_ff  <= rsp_last_in;
         rsp_stat_ff  <= rsp_stat_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_coef_ff, rsp_pos_ff};
   assign rsp_tuser  = rsp_stat_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
// testbench for the jpeg huffman coefficient decoder with its scoreboard class
`timescale 1ns / 100ps

typedef struct {
   bit [5:0]  position;
   bit [15:0] coefficient;
   bit        last;
   bit [1:0]  status;
} coef_result_type;

typedef enum int {DEC_IDLE, DEC_CODE, DEC_MAG} dec_phase_type;

class coef_scoreboard;
   bit [4:0]  ent_len[4][256];
   bit [15:0] ent_code[4][256];
   bit [7:0]  ent_sym[4][256];
   int        ent_count[4];
   bit [15:0] dc_pred[4];
   int        zz_index;
   bit [15:0] accum;
   int        nbits;
   dec_phase_type phase;
   bit [7:0]  run_size;
   bit        dc_sel;
   bit        ac_sel;
   int        comp;
   coef_result_type expected_q[$];
   int        errors;
   bit [5:0]  zz_nat[64] = '{
      0, 1, 8, 16, 9, 2, 3, 10, 17, 24, 32, 25, 18, 11, 4, 5,
      12, 19, 26, 33, 40, 48, 41, 34, 27, 20, 13, 6, 7, 14, 21, 28,
      35, 42, 49, 56, 57, 50, 43, 36, 29, 22, 15, 23, 30, 37, 44, 51,
      58, 59, 52, 45, 38, 31, 39, 46, 53, 60, 61, 54, 47, 55, 62, 63};

   function new();
      ent_count = '{0, 0, 0, 0};
      dc_pred = '{0, 0, 0, 0};
      zz_index = 0;
      accum = 0;
      nbits = 0;
      phase = DEC_IDLE;
      run_size = 0;
      dc_sel = 0;
      ac_sel = 0;
      comp = 0;
      errors = 0;
   endfunction

   function void push(bit [5:0] pos, bit [15:0] coef, bit last, bit [1:0] st);
      coef_result_type r;
      r.position = pos;
      r.coefficient = coef;
      r.last = last;
      r.status = st;
      expected_q.push_back(r);
   endfunction

   function void abort_block(bit [1:0] st);
      push(zz_nat[zz_index & 63], 16'd0, 1'b1, st);
      phase = DEC_IDLE;
   endfunction

   function int find_symbol(int tab, int len, bit [15:0] code);
      for (int i = 0; i < ent_count[tab]; i++)
         if (ent_len[tab][i] == len && ent_code[tab][i] == code) return ent_sym[tab][i];
      return -1;
   endfunction

   function void emit_run(int run, bit [15:0] value);
      bit [5:0] pos;
      for (int i = 0; i <= run && zz_index < 64; i++) begin
         pos = zz_nat[zz_index];
         zz_index++;
         push(pos, (i == run) ? value : 16'd0, zz_index == 64, jhcd_pkg::STAT_OK);
      end
      phase = (zz_index >= 64) ? DEC_IDLE : DEC_CODE;
   endfunction

   function void decode_bit(bit b);
      int tab;
      int sym;
      int run;
      int size;
      bit [31:0] v;
      bit [31:0] val;
      if (phase == DEC_IDLE) return;
      accum = {accum[14:0], b};
      nbits++;
      if (phase == DEC_CODE) begin
         tab = (zz_index == 0) ? dc_sel : 2 + ac_sel;
         sym = find_symbol(tab, nbits, accum);
         if (sym < 0) begin
            if (nbits >= jhcd_pkg::MAX_CODE_LEN) abort_block(jhcd_pkg::STAT_NO_CODE);
            return;
         end
         accum = 0;
         nbits = 0;
         run_size = 8'(sym);
         if (zz_index == 0) begin
            if (sym > 16) begin
               abort_block(jhcd_pkg::STAT_BAD_SYM);
            end else if (sym == 0) begin
               push(6'd0, dc_pred[comp], 1'b0, jhcd_pkg::STAT_OK);
               zz_index = 1;
            end else begin
               phase = DEC_MAG;
            end
            return;
         end
         run = sym[7:4];
         size = sym[3:0];
         if (size == 0 && run == 0) begin
            emit_run(63 - zz_index, 16'd0);
            return;
         end
         if (size == 0 && run != 15) begin
            abort_block(jhcd_pkg::STAT_BAD_SYM);
            return;
         end
         if (zz_index + run + 1 > 64) begin
            abort_block(jhcd_pkg::STAT_OVERRUN);
            return;
         end
         if (size == 0) emit_run(run, 16'd0);
         else phase = DEC_MAG;
         return;
      end
      size = (zz_index == 0) ? run_size : run_size[3:0];
      if (size == 0 || size > 16) begin
         abort_block(jhcd_pkg::STAT_BAD_SYM);
         return;
      end
      if (nbits < size) return;
      v = accum;
      if (v[size-1]) val = v;
      else val = v - ((32'd1 << size) - 1);
      accum = 0;
      nbits = 0;
      if (zz_index == 0) begin
         dc_pred[comp] = dc_pred[comp] + val[15:0];
         push(6'd0, dc_pred[comp], 1'b0, jhcd_pkg::STAT_OK);
         zz_index = 1;
         phase = DEC_CODE;
         return;
      end
      emit_run(run_size[7:4], val[15:0]);
   endfunction

   function void note_input(bit [1:0] op, bit [39:0] d);
      int t;
      case (op)
         jhcd_pkg::OP_LOAD: begin
            t = d[1:0];
            if (ent_count[t] < jhcd_pkg::ENTRIES_PER_TABLE) begin
               ent_len[t][ent_count[t]] = d[6:2];
               ent_code[t][ent_count[t]] = d[22:7];
               ent_sym[t][ent_count[t]] = d[30:23];
               ent_count[t]++;
            end
         end
         jhcd_pkg::OP_START: begin
            dc_sel = d[31];
            ac_sel = d[32];
            comp = d[34:33];
            if (comp >= jhcd_pkg::COMPONENTS) comp = jhcd_pkg::COMPONENTS - 1;
            zz_index = 0;
            accum = 0;
            nbits = 0;
            run_size = 0;
            phase = DEC_CODE;
         end
         jhcd_pkg::OP_CLEAR: dc_pred = '{0, 0, 0, 0};
         default: decode_bit(d[35]);
      endcase
   endfunction

   function void check_result(bit [5:0] pos, bit [15:0] coef, bit last, bit [1:0] st);
      coef_result_type e;
      if (expected_q.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("unexpected transfer: pos %0d coef %h last %b status %0d",
                     pos, coef, last, st);
         return;
      end
      e = expected_q.pop_front();
      if (e.position != pos || e.coefficient != coef || e.last != last || e.status != st) begin
         errors++;
         if (errors <= 10)
            $display({"mismatch: exp pos %0d coef %h last %b st %0d, ",
                      "got pos %0d coef %h last %b st %0d"},
                     e.position, e.coefficient, e.last, e.status, pos, coef, last, st);
      end
   endfunction
endclass

module tb;
   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [1:0]  req_tuser = jhcd_pkg::OP_LOAD;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   coef_scoreboard sb = new();
   int  burst_left = 0;
   int  sent_items = 0;
   bit  hold_req = 0;
   int  hold_cnt = 0;
   int  cycles = 0;
   int  rx_mode = 0;
   bit [15:0] rx_mask = 16'hffff;
   bit [7:0]  ac0_syms[26] = '{8'h00, 8'hF0, 8'h10, 8'h01, 8'h02, 8'h03, 8'h05, 8'h08,
                              8'h0A, 8'h0F, 8'h11, 8'h12, 8'h21, 8'h23, 8'h31, 8'h42,
                              8'h52, 8'h61, 8'hA1, 8'hB4, 8'hD2, 8'hE1, 8'hF1, 8'hF3,
                              8'hFA, 8'h3F};

   jpeg_huffman_coefficient_decoder_top DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > 3000000) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // result side: check transfers, stall on a changing pattern, one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata[5:0], rsp_tdata[21:6], rsp_tlast, rsp_tuser);
         if (cycles % 128 == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_mask = 16'($urandom);
         end
         if (hold_req) begin
            hold_req = 0;
            hold_cnt = 600;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_tready <= 0;
         end else begin
            case (rx_mode)
               0: rsp_tready <= 1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= ($urandom_range(0, 4) != 0);
               default: rsp_tready <= rx_mask[cycles % 16];
            endcase
         end
      end
   end

   task automatic send_item(input logic [1:0] op, input logic [39:0] d);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1;
      req_tuser <= op;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      sb.note_input(op, d);
      sent_items++;
   endtask

   task automatic load_entry(input int t, input int len, input int code, input int sym);
      logic [39:0] d;
      d = {4'd0, 5'($urandom), 31'd0};
      d[1:0] = 2'(t);
      d[6:2] = 5'(len);
      d[22:7] = 16'(code);
      d[30:23] = 8'(sym);
      send_item(jhcd_pkg::OP_LOAD, d);
   endtask

   task automatic send_bit(input bit b);
      logic [39:0] d;
      d = {4'd0, b, 35'($urandom)};
      send_item(jhcd_pkg::OP_BIT, d);
   endtask

   task automatic send_code(input int len, input bit [31:0] code);
      for (int i = len - 1; i >= 0; i--) send_bit(code[i]);
   endtask

   task automatic send_start(input bit dct, input bit act, input bit [1:0] c);
      logic [39:0] d;
      d = {4'd0, 1'($urandom), c, act, dct, 31'($urandom)};
      send_item(jhcd_pkg::OP_START, d);
   endtask

   task automatic send_clear();
      send_item(jhcd_pkg::OP_CLEAR, {4'd0, 36'($urandom)});
   endtask

   // one block with random content; mostly well formed, sometimes broken
   task automatic run_block(input bit dct, input bit act, input bit [1:0] c, input bit short_eob);
      int r;
      int sym;
      int pos;
      int run;
      int size;
      send_start(dct, act, c);
      r = $urandom_range(0, 19);
      if (r == 19) begin
         if (dct) send_code(16, {16'hD, 12'($urandom)} << 0 | 32'hD000);
         else send_code(16, 32'hF800 | 11'($urandom));
         return;
      end
      if (dct) sym = (r == 18) ? 16 : $urandom_range(0, 11);
      else sym = (r == 18) ? 17 : (r == 17) ? $urandom_range(12, 16) : $urandom_range(0, 11);
      if (dct) send_code(sym == 16 ? 16 : 4, sym == 16 ? 32'hFFFF : sym);
      else send_code(5, sym);
      if (sym > 16) return;
      if (sym > 0) send_code(sym, $urandom);
      pos = 1;
      while (pos < 64) begin
         if ($urandom_range(0, 49) == 0) send_clear();
         if ($urandom_range(0, 79) == 0) return;
         if (short_eob || $urandom_range(0, 5) == 0) sym = 0;
         else if (act) sym = $urandom_range(0, 255);
         else if ($urandom_range(0, 49) == 0) sym = -1;
         else sym = ac0_syms[$urandom_range(1, 25)];
         if (sym < 0) begin
            send_code(16, 32'hFC00 | 10'($urandom));
            return;
         end
         if (act) send_code(8, sym);
         else for (int i = 0; i < 26; i++) if (ac0_syms[i] == sym) send_code(6, i);
         run = sym >> 4;
         size = sym & 15;
         if (sym == 0 || (size == 0 && run != 15) || pos + run + 1 > 64) return;
         if (size > 0) send_code(size, $urandom);
         pos += run + 1;
      end
   endtask

   initial begin
      int nblocks;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // tables: dc0 5-bit codes, dc1 4-bit codes plus one 16-bit, ac0 6-bit, ac1 full 8-bit
      for (int k = 0; k < 18; k++) load_entry(0, 5, k, k);
      load_entry(0, 5, 0, 9);
      load_entry(0, 0, 0, 3);
      load_entry(0, 20, 1, 4);
      load_entry(0, 3, 16'hFFF8, 5);
      for (int k = 0; k < 12; k++) load_entry(1, 4, k, k);
      load_entry(1, 16, 16'hFFFF, 16);
      for (int k = 0; k < 26; k++) load_entry(2, 6, k, ac0_syms[k]);
      for (int k = 0; k < 256; k++) load_entry(3, 8, k, k);
      load_entry(3, 8, 0, 8'h55);
      load_entry(3, 1, 1, 8'hAA);

      // directed cases
      send_bit(1);
      send_bit(0);
      send_start(0, 0, 3);
      send_code(5, 0);
      send_code(6, 0);
      send_start(1, 0, 1);
      send_code(16, 32'hFFFF);
      send_code(16, 0);
      send_code(6, 1);
      send_start(1, 0, 1);
      send_code(16, 32'hFFFF);
      send_code(16, 32'hFFFF);
      send_clear();
      send_code(6, 0);
      send_start(0, 0, 0);
      send_code(16, 32'hF800);
      send_start(0, 0, 2);
      send_code(5, 17);
      send_start(0, 0, 2);
      send_code(5, 0);
      send_code(6, 2);

      nblocks = 0;
      while (sent_items < 470 || nblocks < 2) begin
         if (nblocks == 0) hold_req = 1;
         if ($urandom_range(0, 15) == 0) send_bit(1'($urandom));
         if ($urandom_range(0, 19) == 0) send_clear();
         run_block(1'($urandom), $urandom_range(0, 9) == 0, 2'($urandom), nblocks == 0);
         nblocks++;
      end
      req_tvalid <= 0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule

// File: files.f
rtl/core/jhcd_pkg.sv
rtl/core/jhcd_code_table.sv
rtl/core/jpeg_huffman_coefficient_decoder_top.sv
tb/sv/tb.sv
